FILE: rtl/smbmgt_pkg.sv
`timescale 1ns / 1ps
// smbmgt_pkg: types, codes and constants of the SMBus management register port.
// No dependencies. Used by every module of the block.
package smbmgt_pkg;

  // register bank geometry
  localparam int REG_WORDS = 1024;
  localparam int ADDR_W    = $clog2(REG_WORDS);
  localparam int PTR_W     = 10;
  localparam int BE_W      = 4;
  localparam int BR_W      = 3;

  // special words
  localparam logic [PTR_W-1:0] TEMP_BASE     = PTR_W'(12'h5d8 >> 2);
  localparam int               TEMP_COUNT    = 3;
  localparam logic [PTR_W-1:0] VERSION_WORD  = PTR_W'(12'h700 >> 2);
  localparam logic [31:0]      VERSION_VALUE = 32'h0102_0304;
  localparam logic [31:0]      TEMP_READY    = 32'h0080_0000;

  // command opcodes
  localparam logic [2:0] OP_WRITE = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;

  // framing
  localparam logic [7:0]      CMD_BYTES  = 8'd4;
  localparam logic [BR_W-1:0] WORD_BYTES = BR_W'(4);

  typedef enum logic [1:0] {
    FUNC_WRITE_BLOCK = 2'd0,
    FUNC_READ_BYTE   = 2'd1,
    FUNC_SENSOR      = 2'd2
  } func_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT     = 3'd1,
    ST_READ_PAST = 3'd2,
    ST_EXCESS    = 3'd3,
    ST_PROTECTED = 3'd4,
    ST_UNKNOWN   = 3'd5
  } status_e;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  block_length;
    logic [31:0] command_word;
    logic [31:0] payload_word;
    logic [1:0]  sensor_index;
    logic [11:0] temp_code;
  } in_req_t;

  typedef struct packed {
    logic [7:0] read_data;
    status_e    status;
  } out_rsp_t;

  typedef struct packed {
    logic [PTR_W-1:0] ptr;
    logic [BE_W-1:0]  be;
    logic [BR_W-1:0]  br;
  } port_state_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [31:0]       data;
  } mem_wr_t;

  typedef struct packed {
    logic        state_we;
    port_state_t nxt;
    mem_wr_t     wr;
    out_rsp_t    rsp;
  } upd_t;

endpackage

FILE: rtl/smbmgt_regfile.sv
`timescale 1ns / 1ps
// smbmgt_regfile: register word memory with one write and one registered read port,
// write-to-read bypass and the clearing pass after reset. Depends on smbmgt_pkg.
module smbmgt_regfile (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [smbmgt_pkg::ADDR_W-1:0] rd_addr_i,
  input  smbmgt_pkg::mem_wr_t        wr_i,
  output logic [31:0]                rd_data_o,
  output logic                       clr_busy_o
);

  logic [31:0] mem [smbmgt_pkg::REG_WORDS];

  logic                          clr_busy_q;
  logic [smbmgt_pkg::ADDR_W-1:0] clr_cnt_q;
  logic                          byp_q;
  logic [31:0]                   byp_data_q;
  logic [31:0]                   rd_q;
  smbmgt_pkg::mem_wr_t           wr;

  // clearing pass owns the write port until it is done
  always_comb begin
    if (clr_busy_q) begin
      wr.en   = 1'b1;
      wr.addr = clr_cnt_q;
      wr.data = (clr_cnt_q == smbmgt_pkg::VERSION_WORD[smbmgt_pkg::ADDR_W-1:0]) ?
                smbmgt_pkg::VERSION_VALUE : 32'd0;
    end else begin
      wr = wr_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clr_busy_q) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
      if (clr_cnt_q == smbmgt_pkg::ADDR_W'(smbmgt_pkg::REG_WORDS - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_q <= mem[rd_addr_i];
  end

  // a write at the address being read returns the new data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else begin
      byp_q <= wr.en && (wr.addr == rd_addr_i);
    end
  end

  always_ff @(posedge clk_i) begin
    byp_data_q <= wr.data;
  end

  assign rd_data_o  = byp_q ? byp_data_q : rd_q;
  assign clr_busy_o = clr_busy_q;

endmodule

FILE: rtl/smbmgt_exec.sv
`timescale 1ns / 1ps
// smbmgt_exec: decodes one request against the port state and the selected word,
// giving state, memory write and response. Depends on smbmgt_pkg.
module smbmgt_exec (
  input  smbmgt_pkg::in_req_t     req_i,
  input  smbmgt_pkg::port_state_t st_i,
  input  logic [31:0]             word_i,
  output smbmgt_pkg::upd_t        upd_o
);

  logic [smbmgt_pkg::PTR_W-1:0] cmd_ptr;
  logic [smbmgt_pkg::BE_W-1:0]  cmd_be;
  logic [2:0]                   cmd_op;
  logic [7:0]                   ndata;
  logic [3:0]                   lane_en;
  logic [31:0]                  wr_word;
  logic                         cmd_in_range;
  logic                         st_in_range;
  logic                         cmd_is_temp;
  logic [7:0]                   rd_byte;

  assign cmd_ptr = {req_i.command_word[17:16], req_i.command_word[31:24]};
  assign cmd_be  = req_i.command_word[21:18];
  assign cmd_op  = req_i.command_word[2:0];
  assign ndata   = req_i.block_length - smbmgt_pkg::CMD_BYTES;

  assign cmd_in_range = {1'b0, cmd_ptr} < (smbmgt_pkg::PTR_W + 1)'(smbmgt_pkg::REG_WORDS);
  assign st_in_range  = {1'b0, st_i.ptr} < (smbmgt_pkg::PTR_W + 1)'(smbmgt_pkg::REG_WORDS);
  assign cmd_is_temp  = (cmd_ptr >= smbmgt_pkg::TEMP_BASE) &&
                        (cmd_ptr < smbmgt_pkg::TEMP_BASE +
                                   smbmgt_pkg::PTR_W'(smbmgt_pkg::TEMP_COUNT));

  // big-endian data lanes, each kept only when enabled and present
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      lane_en[i]           = cmd_be[i] && (ndata > 8'(i));
      wr_word[31-8*i -: 8] = lane_en[i] ? req_i.payload_word[31-8*i -: 8] : 8'd0;
    end
  end

  assign rd_byte = 8'(word_i >> {~st_i.br[1:0], 3'b000});

  always_comb begin
    upd_o          = '0;
    upd_o.nxt      = st_i;
    upd_o.rsp.status = smbmgt_pkg::ST_OK;
    case (req_i.func)
      smbmgt_pkg::FUNC_WRITE_BLOCK: begin
        if (req_i.block_length < smbmgt_pkg::CMD_BYTES) begin
          upd_o.rsp.status = smbmgt_pkg::ST_SHORT;
        end else begin
          upd_o.state_we = 1'b1;
          upd_o.nxt.ptr  = cmd_ptr;
          upd_o.nxt.be   = cmd_be;
          upd_o.nxt.br   = '0;
          if (!cmd_in_range || cmd_op == smbmgt_pkg::OP_READ) begin
            upd_o.rsp.status = smbmgt_pkg::ST_OK;
          end else if (cmd_op != smbmgt_pkg::OP_WRITE) begin
            upd_o.rsp.status = smbmgt_pkg::ST_UNKNOWN;
          end else if (cmd_is_temp) begin
            upd_o.rsp.status = smbmgt_pkg::ST_PROTECTED;
          end else begin
            upd_o.wr.en      = 1'b1;
            upd_o.wr.addr    = cmd_ptr[smbmgt_pkg::ADDR_W-1:0];
            upd_o.wr.data    = wr_word;
            upd_o.rsp.status = (ndata > 8'd4) ? smbmgt_pkg::ST_EXCESS : smbmgt_pkg::ST_OK;
          end
        end
      end
      smbmgt_pkg::FUNC_READ_BYTE: begin
        if (!st_in_range) begin
          upd_o.rsp.status = smbmgt_pkg::ST_OK;
        end else if (st_i.br >= smbmgt_pkg::WORD_BYTES) begin
          upd_o.rsp.status = smbmgt_pkg::ST_READ_PAST;
        end else begin
          upd_o.state_we      = 1'b1;
          upd_o.nxt.br        = st_i.br + 1'b1;
          upd_o.rsp.read_data = st_i.be[st_i.br[1:0]] ? rd_byte : 8'd0;
        end
      end
      smbmgt_pkg::FUNC_SENSOR: begin
        if (req_i.sensor_index < 2'(smbmgt_pkg::TEMP_COUNT)) begin
          upd_o.wr.en   = 1'b1;
          upd_o.wr.addr = smbmgt_pkg::ADDR_W'(smbmgt_pkg::TEMP_BASE +
                                               smbmgt_pkg::PTR_W'(req_i.sensor_index));
          upd_o.wr.data = smbmgt_pkg::TEMP_READY | (32'(req_i.temp_code) << 8);
        end
      end
      default: begin
        upd_o.rsp.status = smbmgt_pkg::ST_OK;
      end
    endcase
  end

endmodule

FILE: rtl/smbus_switch_mgmt_register_port.sv
`timescale 1ns / 1ps
// smbus_switch_mgmt_register_port: top level of the SMBus management register port.
// Depends on smbmgt_pkg, smbmgt_regfile and smbmgt_exec.
//
//   channel | handshake               | payload
//   --------+-------------------------+------------------------------------------
//   in      | in_valid_i / in_stall_o | in_req_i   (func, length, command, data,
//           |                         |             sensor index, temp code)
//   out     | out_valid_o/out_stall_i | out_rsp_o  (read_data, status)
//
// one request per cycle sustained while out_stall_i is low and no clearing pass runs;
// each request gives exactly one response, which goes from the request register to
// the response register and out_rsp_o; the request register and the registered memory
// read feed one pass of decode logic into the response register; the word read is
// bypassed on a same-cycle write; after reset a clearing pass writes all REG_WORDS words,
// with the version word loaded on the way; in_stall_o stays high until it is done
// a stalled response holds the request register, which then stalls the input
module smbus_switch_mgmt_register_port (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  smbmgt_pkg::in_req_t  in_req_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output smbmgt_pkg::out_rsp_t out_rsp_o
);

  // request register
  logic                    s1_valid_q;
  smbmgt_pkg::in_req_t     s1_req_q;
  logic                    s1_fire;
  logic                    in_acc;

  // port state: word pointer, byte enables, bytes read
  smbmgt_pkg::port_state_t st_q;

  // response register
  logic                    out_valid_q;
  smbmgt_pkg::out_rsp_t    out_rsp_q;

  // memory side
  logic                    clr_busy;
  logic [smbmgt_pkg::ADDR_W-1:0] rd_addr;
  logic [31:0]             word;
  smbmgt_pkg::mem_wr_t     mem_wr;
  smbmgt_pkg::upd_t        upd;

  // a request leaves the request register when the response register is free
  assign s1_fire    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = clr_busy || (s1_valid_q && !s1_fire);
  assign in_acc     = in_valid_i && !in_stall_o;

  smbmgt_exec u_exec (
    .req_i  (s1_req_q),
    .st_i   (st_q),
    .word_i (word),
    .upd_o  (upd)
  );

  // the memory reads at the pointer the next request will see
  assign rd_addr = (s1_fire && upd.state_we) ? upd.nxt.ptr[smbmgt_pkg::ADDR_W-1:0]
                                             : st_q.ptr[smbmgt_pkg::ADDR_W-1:0];

  always_comb begin
    mem_wr    = upd.wr;
    mem_wr.en = s1_fire && upd.wr.en;
  end

  smbmgt_regfile u_regfile (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_addr_i  (rd_addr),
    .wr_i       (mem_wr),
    .rd_data_o  (word),
    .clr_busy_o (clr_busy)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_req_q <= in_req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (s1_fire && upd.state_we) begin
      st_q <= upd.nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_rsp_q <= upd.rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  // no request gets in while the clearing pass runs
  a_clear_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy |-> (in_stall_o && !s1_valid_q))
    else $error("request taken during clearing pass");

  // a finished request lands in the response register with its response
  a_fire_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire |=> (out_valid_q && out_rsp_q == $past(upd.rsp)))
    else $error("response lost after request left the request register");

  // reading past the word leaves the byte count at four
  a_read_past: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && s1_req_q.func == smbmgt_pkg::FUNC_READ_BYTE &&
     upd.rsp.status == smbmgt_pkg::ST_READ_PAST) |=> (st_q.br == smbmgt_pkg::WORD_BYTES))
    else $error("byte count moved on a read past the word");

  // an accepted request is held in the request register the next cycle
  a_accept_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> s1_valid_q)
    else $error("accepted request not registered");

endmodule
